### rtl/lir_pkg.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler package
// Shared widths, limits, register indexes, state encoding and the command
// and status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lir_pkg;

    // Block limits.
    localparam int BLOCK_MAX   = 4096;
    localparam int STRETCH_MAX = 16;
    localparam int MAX_RESULTS = 2 * STRETCH_MAX;

    // Field and state widths.
    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 21;
    localparam int INLEN_W  = 13;
    localparam int OUTLEN_W = 17;
    localparam int PHASE_W  = 29;
    localparam int FRAC_W   = 16;
    localparam int RESCNT_W = $clog2(MAX_RESULTS + 1);

    // Configuration port.
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    // Register indexes (word address within the port).
    localparam logic [1:0] REG_STEP       = 2'd0;
    localparam logic [1:0] REG_IN_LENGTH  = 2'd1;
    localparam logic [1:0] REG_OUT_LENGTH = 2'd2;

    // Register reset values.
    localparam logic [STEP_W-1:0]   STEP_RESET       = STEP_W'(65536);
    localparam logic [INLEN_W-1:0]  IN_LENGTH_RESET  = INLEN_W'(512);
    localparam logic [OUTLEN_W-1:0] OUT_LENGTH_RESET = OUTLEN_W'(512);

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [STEP_W-1:0]   step;
        logic [INLEN_W-1:0]  in_length;
        logic [OUTLEN_W-1:0] out_length;
    } cfg_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INTERP,
        ST_HOLD,
        ST_FLUSH
    } lir_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;            // take a new input sample
        logic produce_interp;  // emit one blended result and advance the phase
        logic produce_hold;    // emit one copy of the last sample
        logic advance_only;    // count one dropped output and advance the phase
        logic jump_to_end;     // count every remaining output as dropped
        logic finish;          // release the held result and update block state
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_interval;
        logic is_last;
        logic phase_lt_end;
        logic count_lt_out;
        logic n_full;
        logic pend_valid;
        logic out_free;
        logic step_zero;
    } dp_status_t;

endpackage

### rtl/lir_cfg.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler configuration registers
// APB-style register file holding step, in_length and out_length.
// ----------------------------------------------------------------------------
module lir_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [lir_pkg::ADDR_W-1:0] paddr,
    input  logic [lir_pkg::DATA_W-1:0] pwdata,
    output logic [lir_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output lir_pkg::cfg_t              cfg
);

    logic [lir_pkg::STEP_W-1:0]   step_reg,       step_next;
    logic [lir_pkg::INLEN_W-1:0]  in_length_reg,  in_length_next;
    logic [lir_pkg::OUTLEN_W-1:0] out_length_reg, out_length_next;
    logic                         wr_en;
    logic [1:0]                   reg_sel;

    // The port never inserts wait states.
    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    // Write decode.
    always_comb begin
        step_next       = step_reg;
        in_length_next  = in_length_reg;
        out_length_next = out_length_reg;
        if (wr_en) begin
            unique case (reg_sel)
                lir_pkg::REG_STEP:       step_next       = pwdata[lir_pkg::STEP_W-1:0];
                lir_pkg::REG_IN_LENGTH:  in_length_next  = pwdata[lir_pkg::INLEN_W-1:0];
                lir_pkg::REG_OUT_LENGTH: out_length_next = pwdata[lir_pkg::OUTLEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= lir_pkg::STEP_RESET;
            in_length_reg  <= lir_pkg::IN_LENGTH_RESET;
            out_length_reg <= lir_pkg::OUT_LENGTH_RESET;
        end else begin
            step_reg       <= step_next;
            in_length_reg  <= in_length_next;
            out_length_reg <= out_length_next;
        end
    end

    // Read-back multiplexer.
    always_comb begin
        unique case (reg_sel)
            lir_pkg::REG_STEP:       prdata = lir_pkg::DATA_W'(step_reg);
            lir_pkg::REG_IN_LENGTH:  prdata = lir_pkg::DATA_W'(in_length_reg);
            lir_pkg::REG_OUT_LENGTH: prdata = lir_pkg::DATA_W'(out_length_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.step       = step_reg;
    assign cfg.in_length  = in_length_reg;
    assign cfg.out_length = out_length_reg;

endmodule

### rtl/lir_dp.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler datapath
// Phase accumulator, block counters, blend multiplier, a one-entry holding
// stage for the newest result and the output register.
// ----------------------------------------------------------------------------
module lir_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lir_pkg::cfg_t                       cfg,
    input  lir_pkg::dp_cmd_t                    cmd,
    output lir_pkg::dp_status_t                 status,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic signed [lir_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic                                m_block_end,
    output logic                                m_valid,
    input  logic                                m_ready
);

    // Block state.
    logic signed [lir_pkg::SAMPLE_W-1:0] prev_reg,  prev_next;
    logic signed [lir_pkg::SAMPLE_W-1:0] cur_reg,   cur_next;
    logic [lir_pkg::PHASE_W-1:0]         phase_reg, phase_next;
    logic [lir_pkg::INLEN_W-1:0]         index_reg, index_next;
    logic [lir_pkg::OUTLEN_W-1:0]        count_reg, count_next;
    logic [lir_pkg::RESCNT_W-1:0]        n_reg,     n_next;
    logic                                start_lt_reg, start_lt_next;

    // Holding stage and output register.
    logic signed [lir_pkg::SAMPLE_W-1:0] pend_reg, pend_next;
    logic                                pend_valid_reg, pend_valid_next;
    logic signed [lir_pkg::SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                                out_end_reg, out_end_next;
    logic                                out_valid_reg, out_valid_next;

    // Combinational helpers.
    logic [lir_pkg::INLEN_W-1:0]         len;
    logic [lir_pkg::INLEN_W-1:0]         index_dec;
    logic [lir_pkg::PHASE_W-1:0]         end_pos;
    logic [lir_pkg::PHASE_W-1:0]         base_pos;
    logic [lir_pkg::PHASE_W-1:0]         frac_diff;
    logic [lir_pkg::FRAC_W-1:0]          frac;
    logic [lir_pkg::PHASE_W:0]           phase_sum;
    logic [lir_pkg::PHASE_W-1:0]         phase_adv;
    logic signed [lir_pkg::SAMPLE_W:0]   delta;
    logic signed [lir_pkg::FRAC_W:0]     frac_s;
    logic signed [2*lir_pkg::SAMPLE_W+1:0] prod;
    logic signed [lir_pkg::SAMPLE_W+1:0] blend_sum;
    logic signed [lir_pkg::SAMPLE_W-1:0] blend;
    logic signed [lir_pkg::SAMPLE_W-1:0] new_value;
    logic                                is_last;
    logic                                count_lt_out;
    logic                                out_free;

    // Effective block length: zero counts as one, the top is clamped.
    always_comb begin
        if (cfg.in_length == '0) begin
            len = lir_pkg::INLEN_W'(1);
        end else if (cfg.in_length > lir_pkg::INLEN_W'(lir_pkg::BLOCK_MAX)) begin
            len = lir_pkg::INLEN_W'(lir_pkg::BLOCK_MAX);
        end else begin
            len = cfg.in_length;
        end
    end

    assign is_last      = ({1'b0, index_reg} + 14'd1) >= {1'b0, len};
    assign count_lt_out = count_reg < cfg.out_length;
    assign out_free     = !out_valid_reg || m_ready;

    // Interval bounds of the current input sample.
    assign index_dec = index_reg - lir_pkg::INLEN_W'(1);
    assign end_pos   = {index_reg, {lir_pkg::FRAC_W{1'b0}}};
    assign base_pos  = {index_dec, {lir_pkg::FRAC_W{1'b0}}};
    assign frac_diff = phase_reg - base_pos;

    // Fraction within the interval; a phase below it blends at zero.
    always_comb begin
        if (phase_reg < base_pos) begin
            frac = '0;
        end else if (|frac_diff[lir_pkg::PHASE_W-1:lir_pkg::FRAC_W]) begin
            frac = '1;
        end else begin
            frac = frac_diff[lir_pkg::FRAC_W-1:0];
        end
    end

    // Saturating phase advance.
    assign phase_sum = {1'b0, phase_reg} + (lir_pkg::PHASE_W+1)'(cfg.step);
    assign phase_adv = phase_sum[lir_pkg::PHASE_W] ? '1 : phase_sum[lir_pkg::PHASE_W-1:0];

    // Blend as prev + floor((cur - prev) * f / 2^16), which equals the
    // weighted sum of both neighbours rounded towards minus infinity.
    assign delta     = {cur_reg[lir_pkg::SAMPLE_W-1], cur_reg}
                     - {prev_reg[lir_pkg::SAMPLE_W-1], prev_reg};
    assign frac_s    = {1'b0, frac};
    assign prod      = delta * frac_s;
    assign blend_sum = prod[2*lir_pkg::SAMPLE_W+1:lir_pkg::FRAC_W]
                     + {{2{prev_reg[lir_pkg::SAMPLE_W-1]}}, prev_reg};
    assign blend     = blend_sum[lir_pkg::SAMPLE_W-1:0];
    assign new_value = cmd.produce_interp ? blend : cur_reg;

    // Next-state logic driven by the controller's commands.
    always_comb begin
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        phase_next      = phase_reg;
        index_next      = index_reg;
        count_next      = count_reg;
        n_next          = n_reg;
        start_lt_next   = start_lt_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_sample_next = out_sample_reg;
        out_end_next    = out_end_reg;
        out_valid_next  = out_valid_reg;

        // A taken result leaves the output register.
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        if (cmd.load) begin
            cur_next      = s_sample_in;
            n_next        = '0;
            start_lt_next = count_lt_out;
        end

        // A new result pushes the held one out, which is then not the last.
        if (cmd.produce_interp || cmd.produce_hold) begin
            if (pend_valid_reg) begin
                out_sample_next = pend_reg;
                out_end_next    = 1'b0;
                out_valid_next  = 1'b1;
            end
            pend_next       = new_value;
            pend_valid_next = 1'b1;
            n_next          = n_reg + lir_pkg::RESCNT_W'(1);
            count_next      = count_reg + lir_pkg::OUTLEN_W'(1);
            if (cmd.produce_interp) begin
                phase_next = phase_adv;
            end
        end

        if (cmd.advance_only) begin
            count_next = count_reg + lir_pkg::OUTLEN_W'(1);
            phase_next = phase_adv;
        end

        if (cmd.jump_to_end) begin
            count_next = cfg.out_length;
        end

        // Item done: the held result carries the block end mark if this item
        // completed the block's outputs.
        if (cmd.finish) begin
            if (pend_valid_reg) begin
                out_sample_next = pend_reg;
                out_end_next    = start_lt_reg && !count_lt_out;
                out_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
            if (is_last) begin
                prev_next  = '0;
                phase_next = '0;
                index_next = '0;
                count_next = '0;
            end else begin
                prev_next  = cur_reg;
                index_next = index_reg + lir_pkg::INLEN_W'(1);
            end
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg       <= '0;
            phase_reg      <= '0;
            index_reg      <= '0;
            count_reg      <= '0;
            n_reg          <= '0;
            start_lt_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            prev_reg       <= prev_next;
            phase_reg      <= phase_next;
            index_reg      <= index_next;
            count_reg      <= count_next;
            n_reg          <= n_next;
            start_lt_reg   <= start_lt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        pend_reg       <= pend_next;
        out_sample_reg <= out_sample_next;
        out_end_reg    <= out_end_next;
    end

    assign m_sample_out = out_sample_reg;
    assign m_block_end  = out_end_reg;
    assign m_valid      = out_valid_reg;

    assign status.in_interval  = (index_reg != '0) && (index_reg < len);
    assign status.is_last      = is_last;
    assign status.phase_lt_end = phase_reg < end_pos;
    assign status.count_lt_out = count_lt_out;
    assign status.n_full       = n_reg == lir_pkg::RESCNT_W'(lir_pkg::MAX_RESULTS);
    assign status.pend_valid   = pend_valid_reg;
    assign status.out_free     = out_free;
    assign status.step_zero    = cfg.step == '0;

endmodule

### rtl/lir_ctrl.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler controller
// Sequences one input sample through interpolation, boundary hold and
// release of its final result.
// ----------------------------------------------------------------------------
module lir_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lir_pkg::dp_status_t status,
    output lir_pkg::dp_cmd_t    cmd
);

    lir_pkg::lir_state_t state_reg, state_next;
    logic                interp_more;
    logic                hold_more;
    logic                pend_free;

    // Loop conditions of the two output phases.
    assign interp_more = status.in_interval && status.phase_lt_end && status.count_lt_out;
    assign hold_more   = status.is_last && status.count_lt_out;
    assign pend_free   = !status.pend_valid || status.out_free;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lir_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = lir_pkg::ST_INTERP;
                end
            end
            lir_pkg::ST_INTERP: begin
                if (!interp_more) begin
                    state_next = lir_pkg::ST_HOLD;
                end
            end
            lir_pkg::ST_HOLD: begin
                if (!hold_more) begin
                    state_next = lir_pkg::ST_FLUSH;
                end
            end
            lir_pkg::ST_FLUSH: begin
                if (pend_free) begin
                    state_next = lir_pkg::ST_IDLE;
                end
            end
            default: state_next = lir_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lir_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Command outputs. Once 32 results have been issued for an item the rest
    // are only counted, and a zero step or the hold phase skips straight on.
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            lir_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            lir_pkg::ST_INTERP: begin
                if (interp_more) begin
                    if (status.n_full) begin
                        if (status.step_zero) begin
                            cmd.jump_to_end = 1'b1;
                        end else begin
                            cmd.advance_only = 1'b1;
                        end
                    end else if (pend_free) begin
                        cmd.produce_interp = 1'b1;
                    end
                end
            end
            lir_pkg::ST_HOLD: begin
                if (hold_more) begin
                    if (status.n_full) begin
                        cmd.jump_to_end = 1'b1;
                    end else if (pend_free) begin
                        cmd.produce_hold = 1'b1;
                    end
                end
            end
            lir_pkg::ST_FLUSH: begin
                cmd.finish = pend_free;
            end
            default: ;
        endcase
    end

endmodule

### rtl/linear_interp_resampler.sv
// ----------------------------------------------------------------------------
// Linear interpolation resampler
// Resamples blocks of signed 16-bit samples by a Q16 phase step, blending
// neighbouring samples and holding the last one past the block end.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  s_        in         s_valid / s_ready      s_sample_in
//  m_        out        m_valid / m_ready      m_sample_out, m_block_end
//  APB       in/out     psel, penable, pready  paddr, pwdata, prdata
//
// An input request passes through the idle, interpolation, hold and flush
// states; the single blend unit issues one result a cycle while the holding
// stage is empty or can pass its result on. Outputs beyond 32 per request
// are only counted: one at a time in the interval (all at once with a zero
// step) and all at once at the block end.
// The output register and a one-entry holding stage decouple the two sides;
// a stalled m_ready pauses the issue of results and so the taking of new input.
// Reset is synchronous, active low, and needs no clearing pass.
// ----------------------------------------------------------------------------
module linear_interp_resampler (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lir_pkg::ADDR_W-1:0]          paddr,
    input  logic [lir_pkg::DATA_W-1:0]          pwdata,
    output logic [lir_pkg::DATA_W-1:0]          prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [lir_pkg::SAMPLE_W-1:0] s_sample_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [lir_pkg::SAMPLE_W-1:0] m_sample_out,
    output logic                                m_block_end
);

    lir_pkg::cfg_t       cfg;
    lir_pkg::dp_cmd_t    cmd;
    lir_pkg::dp_status_t status;

    // Configuration registers.
    lir_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer.
    lir_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Phase, counters, blend and output stage.
    lir_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .cmd          (cmd),
        .status       (status),
        .s_sample_in  (s_sample_in),
        .m_sample_out (m_sample_out),
        .m_block_end  (m_block_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule

### tb/sv/tb_linear_interp_resampler.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Linear interpolation resampler regression
// Feeds blocks of signed samples through the resampler under a series of
// register settings. A directed table comes first, then random phases with
// both sides idling at random and a long output stall in phases 1 and 8. Each
// output is compared with the bench's fixed-point predictor or a typed table value.
// ----------------------------------------------------------------------------
module tb_linear_interp_resampler;

    import lir_pkg::*;

    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int DRAIN_LIMIT      = 100_000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 360;
    localparam int REPORT_LIMIT     = 40;
    localparam logic [PHASE_W-1:0] PHASE_SAT = '1;

    // One output as seen on the result channel.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       block_end;
    } resample_result_t;

    // Rows of the directed table.
    typedef enum logic [1:0] { ROW_SETTINGS, ROW_SAMPLE } row_kind_t;
    typedef enum logic [1:0] { EXP_MODEL, EXP_NONE, EXP_ONE } row_check_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [STEP_W-1:0]          step;
        logic [INLEN_W-1:0]         in_len;
        logic [OUTLEN_W-1:0]        out_len;
        logic signed [SAMPLE_W-1:0] sample;
        row_check_t                 check;
        logic signed [SAMPLE_W-1:0] exp_sample;
        logic                       exp_end;
    } stim_row_t;

    logic                       aclk = 1'b0;
    logic                       aresetn;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [ADDR_W-1:0]          paddr;
    logic [DATA_W-1:0]          pwdata;
    logic [DATA_W-1:0]          prdata;
    logic                       pready;
    logic                       s_valid;
    logic                       s_ready;
    logic signed [SAMPLE_W-1:0] s_sample_in;
    logic                       m_valid;
    logic                       m_ready;
    logic signed [SAMPLE_W-1:0] m_sample_out;
    logic                       m_block_end;

    // Register copies and block state of the predictor.
    logic [STEP_W-1:0]          step_q16;
    logic [INLEN_W-1:0]         block_in_len;
    logic [OUTLEN_W-1:0]        block_out_len;
    logic signed [SAMPLE_W-1:0] last_input;
    logic [PHASE_W-1:0]         phase_acc;
    int unsigned                input_pos;
    int unsigned                outputs_made;

    resample_result_t pending_outputs[$];
    resample_result_t fresh_outputs[$];
    stim_row_t        directed_rows[$];

    int  busy_estimate;
    int  send_gap_max;
    int  recv_gap_max;
    bit  long_hold_request;
    int  mismatch_count;
    int  requests_sent;
    int  results_checked;
    int  phases_run;
    int  long_holds;
    int  random_items;
    int  cycle_count;

    linear_interp_resampler dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample_in  (s_sample_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_sample_out (m_sample_out),
        .m_block_end  (m_block_end)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Prints a mismatch line, up to a limit, and counts it.
    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Weighted blend of two neighbours, rounded towards minus infinity.
    function automatic logic signed [SAMPLE_W-1:0] blend_pair(
        input logic signed [SAMPLE_W-1:0] left,
        input logic signed [SAMPLE_W-1:0] right,
        input int unsigned                frac
    );
        longint mix;
        mix = longint'(left) * (longint'(65536) - longint'(frac))
            + longint'(right) * longint'(frac);
        return SAMPLE_W'(mix >>> 16);
    endfunction

    // Works out the outputs caused by one input sample and updates the block state.
    task automatic resample_one_sample(input logic signed [SAMPLE_W-1:0] cur);
        int unsigned       len;
        int unsigned       k;
        int unsigned       start;
        bit                last;
        longint unsigned   base;
        longint unsigned   lim;
        longint unsigned   rem;
        longint unsigned   cnt;
        longint unsigned   p;
        longint unsigned   np;
        int unsigned       frac;
        int                holds;
        resample_result_t  res;

        fresh_outputs.delete();
        len = (block_in_len == 0) ? 1 : block_in_len;
        if (len > BLOCK_MAX) len = BLOCK_MAX;
        k     = input_pos;
        start = outputs_made;
        last  = (k + 1 >= len);
        cnt   = 0;
        holds = 0;

        // Blended outputs that fall inside the interval ending at this sample.
        if (k >= 1 && k < len && outputs_made < block_out_len) begin
            base = 64'(k - 1) << 16;
            lim  = 64'(k) << 16;
            rem  = 64'(block_out_len) - 64'(outputs_made);
            if (64'(phase_acc) < lim) begin
                if (step_q16 == 0) cnt = rem;
                else cnt = (lim - 64'(phase_acc) + 64'(step_q16) - 1) / 64'(step_q16);
                if (cnt > rem) cnt = rem;
            end
            for (longint unsigned i = 0; i < cnt && fresh_outputs.size() < MAX_RESULTS;
                 i++) begin
                p = 64'(phase_acc) + i * 64'(step_q16);
                if (p < base) frac = 0;
                else if (p - base > 65535) frac = 65535;
                else frac = int'(p - base);
                res.sample    = blend_pair(last_input, cur, frac);
                res.block_end = 1'b0;
                fresh_outputs.push_back(res);
            end
            outputs_made += int'(cnt);
            np = 64'(phase_acc) + cnt * 64'(step_q16);
            phase_acc = (np > 64'(PHASE_SAT)) ? PHASE_SAT : PHASE_W'(np);
        end

        // At the block end the last sample is held for every output still owed.
        if (last && outputs_made < block_out_len) begin
            rem = 64'(block_out_len) - 64'(outputs_made);
            holds = 1;
            while (rem > 0 && fresh_outputs.size() < MAX_RESULTS) begin
                res.sample    = cur;
                res.block_end = 1'b0;
                fresh_outputs.push_back(res);
                rem--;
                holds++;
            end
            outputs_made = block_out_len;
        end

        if (start < block_out_len && outputs_made >= block_out_len
            && fresh_outputs.size() > 0) begin
            fresh_outputs[fresh_outputs.size() - 1].block_end = 1'b1;
        end

        if (last) begin
            last_input   = '0;
            phase_acc    = '0;
            input_pos    = 0;
            outputs_made = 0;
        end else begin
            last_input = cur;
            input_pos  = (k + 1) & 32'h1FFF;
        end

        if (3 + int'(cnt) + holds + 1 > busy_estimate) begin
            busy_estimate = 3 + int'(cnt) + holds + 1;
        end
    endtask

    // Offers one sample after a random gap and records what it should produce.
    task automatic send_sample(
        input logic signed [SAMPLE_W-1:0] value,
        input row_check_t                 check,
        input logic signed [SAMPLE_W-1:0] typed_sample,
        input logic                       typed_end
    );
        int               gap;
        resample_result_t typed;

        gap = $urandom_range(0, send_gap_max);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_sample_in <= value;
        do @(posedge aclk); while (!s_ready);

        resample_one_sample(value);
        case (check)
            EXP_MODEL: begin
                foreach (fresh_outputs[i]) pending_outputs.push_back(fresh_outputs[i]);
            end
            EXP_ONE: begin
                typed.sample    = typed_sample;
                typed.block_end = typed_end;
                pending_outputs.push_back(typed);
            end
            default: begin
            end
        endcase
        requests_sent++;
    endtask

    // Waits for every expected output, then lets the block settle.
    task automatic wait_for_idle();
        int waited;

        s_valid <= 1'b0;
        waited = 0;
        @(negedge aclk);
        while (pending_outputs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(negedge aclk);
            waited++;
        end
        if (pending_outputs.size() != 0) begin
            report_mismatch($sformatf("%0d expected outputs never arrived",
                                      pending_outputs.size()));
            pending_outputs.delete();
        end
        @(posedge aclk);
        repeat (busy_estimate + 16) @(posedge aclk);
        busy_estimate = 0;
    endtask

    // One register write: setup cycle, access cycle, then back to idle.
    task automatic write_register(input logic [1:0] index, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({index, 2'b00});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (index)
            REG_STEP:       step_q16      = value[STEP_W-1:0];
            REG_IN_LENGTH:  block_in_len  = value[INLEN_W-1:0];
            REG_OUT_LENGTH: block_out_len = value[OUTLEN_W-1:0];
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    // Drains the block and writes all three registers.
    task automatic apply_settings(
        input logic [STEP_W-1:0]   st,
        input logic [INLEN_W-1:0]  il,
        input logic [OUTLEN_W-1:0] ol
    );
        wait_for_idle();
        write_register(REG_STEP, DATA_W'(st));
        write_register(REG_IN_LENGTH, DATA_W'(il));
        write_register(REG_OUT_LENGTH, DATA_W'(ol));
        phases_run++;
    endtask

    function automatic void add_settings(
        input logic [STEP_W-1:0]   st,
        input logic [INLEN_W-1:0]  il,
        input logic [OUTLEN_W-1:0] ol
    );
        stim_row_t row;
        row         = '0;
        row.kind    = ROW_SETTINGS;
        row.step    = st;
        row.in_len  = il;
        row.out_len = ol;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_sample(
        input logic signed [SAMPLE_W-1:0] value,
        input row_check_t                 check,
        input logic signed [SAMPLE_W-1:0] exp_sample,
        input logic                       exp_end
    );
        stim_row_t row;
        row            = '0;
        row.kind       = ROW_SAMPLE;
        row.sample     = value;
        row.check      = check;
        row.exp_sample = exp_sample;
        row.exp_end    = exp_end;
        directed_rows.push_back(row);
    endfunction

    // Idle spread for one side: none, short or full.
    function automatic int pick_gap_max();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 15;
        endcase
    endfunction

    // One random phase: new settings, then whole blocks, sometimes cut short.
    task automatic run_random_phase(input int phase_no);
        logic [STEP_W-1:0]          st;
        logic [INLEN_W-1:0]         il;
        logic [OUTLEN_W-1:0]        ol;
        int unsigned                eff;
        longint unsigned            natural_len;
        int                         n_items;
        bit                         pressure;
        logic signed [SAMPLE_W-1:0] value;

        pressure = (phase_no == 1) || (phase_no == 8);
        if (pressure) begin
            st = STEP_W'(4096);
            il = INLEN_W'(16);
            ol = OUTLEN_W'(256);
        end else begin
            case ($urandom_range(0, 11))
                0:       st = STEP_W'(4096);
                1:       st = STEP_W'(1048576);
                2:       st = STEP_W'(65536);
                3:       st = '0;
                4:       st = '1;
                5:       st = STEP_W'($urandom_range(256, 4095));
                default: st = STEP_W'($urandom_range(4096, 1048576));
            endcase
            case ($urandom_range(0, 9))
                0:       il = '0;
                1:       il = $urandom_range(0, 1) ? INLEN_W'(8191) : INLEN_W'(4096);
                2:       il = INLEN_W'(1);
                default: il = INLEN_W'($urandom_range(2, 24));
            endcase
            if (st == 0) begin
                ol = OUTLEN_W'($urandom_range(0, 40));
            end else begin
                eff = (il == 0) ? 1 : ((il > BLOCK_MAX) ? BLOCK_MAX : il);
                natural_len = (64'(eff) << 16) / 64'(st);
                case ($urandom_range(0, 7))
                    0:       natural_len = 0;
                    1:       natural_len = 131071;
                    2:       natural_len = natural_len + $urandom_range(0, 5);
                    3:       if (natural_len > 3) natural_len -= $urandom_range(0, 3);
                    default: natural_len = natural_len;
                endcase
                if (natural_len > 131071) natural_len = 131071;
                ol = OUTLEN_W'(natural_len);
            end
        end

        apply_settings(st, il, ol);
        eff = (il == 0) ? 1 : ((il > BLOCK_MAX) ? BLOCK_MAX : il);

        // The output side stops for a long stretch while samples keep coming.
        if (pressure) begin
            send_gap_max      = 0;
            recv_gap_max      = 3;
            long_hold_request = 1'b1;
            n_items           = 48;
        end else begin
            send_gap_max = pick_gap_max();
            recv_gap_max = pick_gap_max();
            n_items = eff * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0) n_items += $urandom_range(0, eff - 1);
            if (n_items > 64) n_items = 64;
        end

        repeat (n_items) begin
            case ($urandom_range(0, 9))
                0:       value = 16'sh8000;
                1:       value = 16'sh7FFF;
                2:       value = '0;
                default: value = SAMPLE_W'($urandom);
            endcase
            send_sample(value, EXP_MODEL, '0, 1'b0);
            random_items++;
        end
    endtask

    // Result side: random stalls, a long hold on request, and the output check.
    initial begin : result_sink
        int               gap;
        resample_result_t want;

        m_ready = 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (long_hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge aclk);
                long_hold_request = 1'b0;
                long_holds++;
            end
            gap = $urandom_range(0, recv_gap_max);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);

            if (pending_outputs.size() == 0) begin
                report_mismatch($sformatf("unexpected output %0d block_end %0b",
                                          m_sample_out, m_block_end));
            end else begin
                want = pending_outputs.pop_front();
                if (m_sample_out !== want.sample) begin
                    report_mismatch($sformatf("sample_out %0d, expected %0d",
                                              m_sample_out, want.sample));
                end
                if (m_block_end !== want.block_end) begin
                    report_mismatch($sformatf("block_end %0b, expected %0b (sample %0d)",
                                              m_block_end, want.block_end, want.sample));
                end
                results_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("linear_interp_resampler regression: fail");
        $finish;
    end

    // Stimulus: reset, directed table, random phases, final drain.
    initial begin : stimulus
        int phase_no;

        aresetn           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        s_valid           = 1'b0;
        s_sample_in       = '0;
        long_hold_request = 1'b0;
        send_gap_max      = 15;
        recv_gap_max      = 15;
        busy_estimate     = 0;
        mismatch_count    = 0;
        requests_sent     = 0;
        results_checked   = 0;
        phases_run        = 0;
        long_holds        = 0;
        random_items      = 0;

        step_q16      = STEP_RESET;
        block_in_len  = IN_LENGTH_RESET;
        block_out_len = OUT_LENGTH_RESET;
        last_input    = '0;
        phase_acc     = '0;
        input_pos     = 0;
        outputs_made  = 0;

        // Reset values: the first output of a block is the first sample.
        add_sample(16'sh7FFF, EXP_NONE, '0, 1'b0);
        add_sample(16'sh8000, EXP_ONE, 16'sh7FFF, 1'b0);
        add_sample(16'sh0000, EXP_ONE, 16'sh8000, 1'b0);
        // Block length shrunk below the current index: the next sample ends it.
        add_settings(STEP_W'(65536), INLEN_W'(2), OUTLEN_W'(512));
        add_sample(16'sd1234, EXP_MODEL, '0, 1'b0);
        // Zero block length is one sample, each block a single held output.
        add_settings(STEP_W'(65536), INLEN_W'(0), OUTLEN_W'(1));
        add_sample(16'sh8000, EXP_ONE, 16'sh8000, 1'b1);
        add_sample(16'sh7FFF, EXP_ONE, 16'sh7FFF, 1'b1);
        add_sample(16'sh5555, EXP_ONE, 16'sh5555, 1'b1);
        add_sample(16'shAAAA, EXP_ONE, 16'shAAAA, 1'b1);
        // No outputs requested at all.
        add_settings(STEP_W'(65536), INLEN_W'(1), OUTLEN_W'(0));
        add_sample(-16'sd1, EXP_NONE, '0, 1'b0);
        // Zero step puts every output in the first interval.
        add_settings('0, INLEN_W'(3), OUTLEN_W'(5));
        add_sample(16'sd100, EXP_NONE, '0, 1'b0);
        add_sample(-16'sd100, EXP_MODEL, '0, 1'b0);
        add_sample(16'sd7, EXP_NONE, '0, 1'b0);
        // Sixteen-fold stretch overruns the per-request output cap at the block end.
        add_settings(STEP_W'(4096), INLEN_W'(2), OUTLEN_W'(64));
        add_sample(16'sh8000, EXP_NONE, '0, 1'b0);
        add_sample(16'sh7FFF, EXP_MODEL, '0, 1'b0);
        // Register extremes, with the block length above the limit.
        add_settings('1, '1, '1);
        add_sample(16'sd1, EXP_NONE, '0, 1'b0);
        add_sample(16'sd2, EXP_ONE, 16'sd1, 1'b0);
        add_sample(16'sd3, EXP_MODEL, '0, 1'b0);
        // Half step: the first sample closes the open block, then one block.
        add_settings(STEP_W'(32768), INLEN_W'(4), OUTLEN_W'(8));
        add_sample(16'sh8000, EXP_MODEL, '0, 1'b0);
        add_sample(16'sh7FFF, EXP_MODEL, '0, 1'b0);
        add_sample(16'sd1000, EXP_MODEL, '0, 1'b0);
        add_sample(-16'sd1000, EXP_MODEL, '0, 1'b0);
        add_sample(16'sd12345, EXP_MODEL, '0, 1'b0);
        // Tiny step: outputs dropped inside one interval and the end marker moved.
        add_settings(STEP_W'(1024), INLEN_W'(2), OUTLEN_W'(128));
        add_sample(16'sd10000, EXP_NONE, '0, 1'b0);
        add_sample(-16'sd10000, EXP_MODEL, '0, 1'b0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_SETTINGS) begin
                apply_settings(directed_rows[r].step, directed_rows[r].in_len,
                               directed_rows[r].out_len);
            end else begin
                send_sample(directed_rows[r].sample, directed_rows[r].check,
                            directed_rows[r].exp_sample, directed_rows[r].exp_end);
            end
        end

        phase_no = 0;
        while (random_items < RANDOM_ITEMS) begin
            run_random_phase(phase_no);
            phase_no++;
        end

        wait_for_idle();

        $display("Sent %0d input requests under %0d register settings; %0d outputs checked.",
                 requests_sent, phases_run, results_checked);
        $display("Long output stalls: %0d; cycles run: %0d; mismatches: %0d.",
                 long_holds, cycle_count, mismatch_count);
        if (mismatch_count == 0) begin
            $display("linear_interp_resampler regression: pass");
        end else begin
            $display("linear_interp_resampler regression: fail");
        end
        $finish;
    end

endmodule
